### src/websocket_frame_deframer_macros.svh
// Assertion macros shared by the checkers of the frame deframer.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

// General property check.
`define WSFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A stalled beat keeps its valid and the named signal unchanged.
`define WSFD_ASSERT_HOLD(lbl, vld, rdy, sig, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (vld && !rdy) |=> (vld && $stable(sig))) else $error(msg);

`endif

### src/wsfd_pkg.sv
`default_nettype none

package wsfd_pkg;

  // Field widths of the byte stream and the frame header.
  localparam int unsigned ByteW = 8;
  localparam int unsigned OpcW  = 4;
  localparam int unsigned LenW  = 7;

  // Masking key: four bytes, indexed by the low bits of the byte count.
  localparam int unsigned KeyDepth = 4;
  localparam int unsigned KeyIdxW  = $clog2(KeyDepth);

  // Header bit positions.
  localparam int unsigned FinBit  = 7;
  localparam int unsigned MaskBit = 7;

  // Largest length that fits the short header form.
  localparam logic [LenW-1:0] MaxLen = LenW'(125);

endpackage

`default_nettype wire

### src/websocket_frame_deframer.sv
`default_nettype none

// WebSocket frame deframer for short frames (payload up to 125 bytes). Received
// bytes enter one per beat on the input channel; header and masking-key bytes
// produce no result, each payload byte produces one result carrying the
// unmasked byte, the frame's FIN bit and opcode, and a mark on the last byte.
// A frame with no payload produces one empty marker result, and a length code
// of 126 or 127 produces one error result after which all input is taken and
// dropped until reset. Every byte is handled in the cycle it is accepted and
// its result sits in the output register on the next cycle, so the block takes
// one byte per clock while its results are taken; the input is ready whenever
// the output register is empty or its beat is being taken in the same cycle.
module websocket_frame_deframer
  import wsfd_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [ByteW-1:0] rx_byte_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [ByteW-1:0]     data_byte_o,
  output logic                 has_data_o,
  output logic                 fin_flag_o,
  output logic [OpcW-1:0]      frame_opcode_o,
  output logic                 last_of_frame_o,
  output logic                 length_error_o
);

  typedef enum logic [2:0] {
    PhHdr0,
    PhHdr1,
    PhKey0,
    PhKey1,
    PhKey2,
    PhKey3,
    PhData,
    PhHalt
  } phase_e;

  phase_e            phase_q, phase_d;
  logic              fin_q, fin_d;
  logic [OpcW-1:0]   opcode_q, opcode_d;
  logic              mask_on_q, mask_on_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [LenW-1:0]   count_q, count_d;
  logic [ByteW-1:0]  key_q [KeyDepth];

  logic              out_valid_q, out_valid_d;
  logic [ByteW-1:0]  data_q, data_d;
  logic              has_data_q, has_data_d;
  logic              fin_out_q, fin_out_d;
  logic [OpcW-1:0]   opcode_out_q, opcode_out_d;
  logic              last_q, last_d;
  logic              err_q, err_d;

  logic              accept;
  logic              emit;
  logic              key_we;
  logic [KeyIdxW-1:0] key_widx;
  logic [LenW:0]     count_inc;
  logic              at_last;

  // The output register parts the two channels.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign count_inc = {1'b0, count_q} + (LenW+1)'(1);
  assign at_last   = count_inc >= {1'b0, len_q};

  // Next state and result for the accepted byte.
  always_comb begin
    phase_d      = phase_q;
    fin_d        = fin_q;
    opcode_d     = opcode_q;
    mask_on_d    = mask_on_q;
    len_d        = len_q;
    count_d      = count_q;
    emit         = 1'b0;
    key_we       = 1'b0;
    key_widx     = KeyIdxW'(phase_q - PhKey0);
    data_d       = '0;
    has_data_d   = 1'b0;
    last_d       = 1'b0;
    err_d        = 1'b0;
    if (accept) begin
      case (phase_q)
        PhHdr0: begin
          fin_d    = rx_byte_i[FinBit];
          opcode_d = rx_byte_i[OpcW-1:0];
          phase_d  = PhHdr1;
        end
        PhHdr1: begin
          mask_on_d = rx_byte_i[MaskBit];
          len_d     = rx_byte_i[LenW-1:0];
          count_d   = '0;
          if (rx_byte_i[LenW-1:0] > MaxLen) begin
            phase_d = PhHalt;
            emit    = 1'b1;
            last_d  = 1'b1;
            err_d   = 1'b1;
          end else if (rx_byte_i[MaskBit]) begin
            phase_d = PhKey0;
          end else if (rx_byte_i[LenW-1:0] == '0) begin
            phase_d = PhHdr0;
            emit    = 1'b1;
            last_d  = 1'b1;
          end else begin
            phase_d = PhData;
          end
        end
        PhKey0, PhKey1, PhKey2: begin
          key_we  = 1'b1;
          phase_d = phase_e'(phase_q + 3'd1);
        end
        PhKey3: begin
          key_we = 1'b1;
          if (len_q == '0) begin
            phase_d = PhHdr0;
            emit    = 1'b1;
            last_d  = 1'b1;
          end else begin
            phase_d = PhData;
          end
        end
        PhData: begin
          emit       = 1'b1;
          has_data_d = 1'b1;
          data_d     = mask_on_q ? (rx_byte_i ^ key_q[count_q[KeyIdxW-1:0]]) : rx_byte_i;
          last_d     = at_last;
          count_d    = count_inc[LenW-1:0];
          if (at_last) begin
            phase_d = PhHdr0;
          end
        end
        default: begin
          phase_d = PhHalt;
        end
      endcase
    end
    fin_out_d    = fin_d;
    opcode_out_d = opcode_d;

    // A result fills the output register; a taken beat empties it.
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control state and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhHdr0;
      fin_q        <= 1'b0;
      opcode_q     <= '0;
      mask_on_q    <= 1'b0;
      len_q        <= '0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      data_q       <= '0;
      has_data_q   <= 1'b0;
      fin_out_q    <= 1'b0;
      opcode_out_q <= '0;
      last_q       <= 1'b0;
      err_q        <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      fin_q       <= fin_d;
      opcode_q    <= opcode_d;
      mask_on_q   <= mask_on_d;
      len_q       <= len_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (emit) begin
        data_q       <= data_d;
        has_data_q   <= has_data_d;
        fin_out_q    <= fin_out_d;
        opcode_out_q <= opcode_out_d;
        last_q       <= last_d;
        err_q        <= err_d;
      end
    end
  end

  // Masking key, written by the four key bytes of a masked frame.
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_q[key_widx] <= rx_byte_i;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign data_byte_o     = data_q;
  assign has_data_o      = has_data_q;
  assign fin_flag_o      = fin_out_q;
  assign frame_opcode_o  = opcode_out_q;
  assign last_of_frame_o = last_q;
  assign length_error_o  = err_q;

endmodule

`default_nettype wire

### src/wsfd_checker.sv
`default_nettype none

`include "websocket_frame_deframer_macros.svh"

module wsfd_checker
  import wsfd_pkg::*;
(
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            in_ready_o,
  input wire logic            out_valid_o,
  input wire logic            out_ready_i,
  input wire logic [ByteW-1:0] data_byte_o,
  input wire logic            has_data_o,
  input wire logic            fin_flag_o,
  input wire logic [OpcW-1:0] frame_opcode_o,
  input wire logic            last_of_frame_o,
  input wire logic            length_error_o
);

  // A stalled result beat holds its payload.
  `WSFD_ASSERT_HOLD(a_out_hold, out_valid_o, out_ready_i, {data_byte_o, has_data_o, fin_flag_o, frame_opcode_o, last_of_frame_o, length_error_o}, "result beat changed while stalled")

  // An error result is an empty, closing beat.
  `WSFD_ASSERT(a_err_shape, (out_valid_o && length_error_o) |-> (!has_data_o && last_of_frame_o), "error result is not an empty last beat")

  // Markers and errors carry a zero data byte.
  `WSFD_ASSERT(a_empty_zero, (out_valid_o && !has_data_o) |-> (data_byte_o == '0), "empty result carries data")

  // Once the error beat is taken the stream stays silent.
  `WSFD_ASSERT(a_halt_quiet, (out_valid_o && out_ready_i && length_error_o) |=> !out_valid_o, "result after length error")

  // An empty output register always leaves the input ready.
  `WSFD_ASSERT(a_ready_free, !out_valid_o |-> in_ready_o, "input stalled with empty output")

endmodule

bind websocket_frame_deframer wsfd_checker u_wsfd_checker (.*);

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import wsfd_pkg::*;

  // Frame opcodes used by the stimulus.
  localparam logic [OpcW-1:0] OpcContinuation = 4'h0;
  localparam logic [OpcW-1:0] OpcText         = 4'h1;
  localparam logic [OpcW-1:0] OpcBinary       = 4'h2;
  localparam logic [OpcW-1:0] OpcClose        = 4'h8;
  localparam logic [OpcW-1:0] OpcPing         = 4'h9;
  localparam logic [OpcW-1:0] OpcReservedCtrl = 4'hF;

  localparam int unsigned ResetCycles = 11;
  localparam int unsigned RandomBeats = 1500;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned StallLimit  = 2000;

  // Parser position within a frame.
  typedef enum logic [2:0] {
    WaitHdr0, WaitHdr1, WaitKey0, WaitKey1, WaitKey2, WaitKey3, InPayload, Halted
  } deframe_phase_e;

  // Ready patterns of the result sink.
  typedef enum int {SinkFree, SinkCoin, SinkEveryFourth, SinkMostly} sink_mode_e;

  // One result beat, field for field.
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             has_data;
    logic             fin;
    logic [OpcW-1:0]  opcode;
    logic             last;
    logic             len_err;
  } frame_beat_t;

  // One directed input beat; a pinned row carries its result written out by hand.
  typedef struct packed {
    logic [ByteW-1:0] rx;
    bit               pinned;
    frame_beat_t      want;
  } stim_row_t;

  localparam frame_beat_t NoBeat = '0;

  // The last two rows end the run with an oversized length code.
  localparam int unsigned DirectedRows = 24;
  localparam int unsigned TailRows     = 2;
  localparam stim_row_t StimTable [DirectedRows] = '{
    // Empty unmasked frame straight after reset.
    '{{1'b0, 3'b000, OpcContinuation}, 1'b0, NoBeat},
    '{{1'b0, 7'd0}, 1'b1, '{8'h00, 1'b0, 1'b0, OpcContinuation, 1'b1, 1'b0}},
    // Single unmasked byte, all ones.
    '{{1'b1, 3'b000, OpcText}, 1'b0, NoBeat},
    '{{1'b0, 7'd1}, 1'b0, NoBeat},
    '{8'hFF, 1'b1, '{8'hFF, 1'b1, 1'b1, OpcText, 1'b1, 1'b0}},
    // Masked two-byte close frame.
    '{{1'b1, 3'b000, OpcClose}, 1'b0, NoBeat},
    '{{1'b1, 7'd2}, 1'b0, NoBeat},
    '{8'hA5, 1'b0, NoBeat},
    '{8'h5A, 1'b0, NoBeat},
    '{8'hFF, 1'b0, NoBeat},
    '{8'h00, 1'b0, NoBeat},
    '{8'h12, 1'b0, NoBeat},
    '{8'h34, 1'b0, NoBeat},
    // Masked empty frame with the reserved bits set, marker after the last key byte.
    '{{1'b0, 3'b111, OpcReservedCtrl}, 1'b0, NoBeat},
    '{{1'b1, 7'd0}, 1'b0, NoBeat},
    '{8'h00, 1'b0, NoBeat},
    '{8'hFF, 1'b0, NoBeat},
    '{8'h55, 1'b0, NoBeat},
    '{8'hAA, 1'b1, '{8'h00, 1'b0, 1'b0, OpcReservedCtrl, 1'b1, 1'b0}},
    // Single unmasked zero byte.
    '{{1'b0, 3'b000, OpcBinary}, 1'b0, NoBeat},
    '{{1'b0, 7'd1}, 1'b0, NoBeat},
    '{8'h00, 1'b1, '{8'h00, 1'b1, 1'b0, OpcBinary, 1'b1, 1'b0}},
    // Extended length code: error beat, then the stream is dead.
    '{{1'b1, 3'b000, OpcPing}, 1'b0, NoBeat},
    '{{1'b1, 7'd127}, 1'b1, '{8'h00, 1'b0, 1'b1, OpcPing, 1'b1, 1'b1}}
  };

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  logic [ByteW-1:0] rx_byte_i   = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [ByteW-1:0] data_byte_o;
  logic             has_data_o;
  logic             fin_flag_o;
  logic [OpcW-1:0]  frame_opcode_o;
  logic             last_of_frame_o;
  logic             length_error_o;

  websocket_frame_deframer uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .data_byte_o    (data_byte_o),
    .has_data_o     (has_data_o),
    .fin_flag_o     (fin_flag_o),
    .frame_opcode_o (frame_opcode_o),
    .last_of_frame_o(last_of_frame_o),
    .length_error_o (length_error_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Deframer state as the testbench sees it.
  deframe_phase_e   dphase       = WaitHdr0;
  logic             fin_held     = 1'b0;
  logic [OpcW-1:0]  opcode_held  = '0;
  logic             mask_on      = 1'b0;
  logic [LenW-1:0]  payload_len  = '0;
  logic [LenW-1:0]  byte_count   = '0;
  logic [ByteW-1:0] key_bytes [KeyDepth];

  frame_beat_t expected_beats [$];
  int unsigned error_count     = 0;
  int unsigned beats_sent      = 0;
  int unsigned results_checked = 0;
  int unsigned frames_seen     = 0;
  int unsigned masked_frames   = 0;
  int unsigned empty_frames    = 0;
  int unsigned burst_left      = 0;
  bit          allow_halt      = 1'b0;
  bit          hold_req        = 1'b0;

  // Advance the deframer state by one received byte and form the result, if any.
  task automatic advance_deframer(input logic [ByteW-1:0] b, output bit produced,
                                  output frame_beat_t beat);
    bit header_done;
    header_done = 1'b0;
    produced    = 1'b0;
    beat        = '0;
    case (dphase)
      WaitHdr0: begin
        fin_held    = b[FinBit];
        opcode_held = b[OpcW-1:0];
        dphase      = WaitHdr1;
      end
      WaitHdr1: begin
        mask_on     = b[MaskBit];
        payload_len = b[LenW-1:0];
        if (payload_len > MaxLen) begin
          dphase       = Halted;
          produced     = 1'b1;
          beat.last    = 1'b1;
          beat.len_err = 1'b1;
        end else if (mask_on) begin
          dphase = WaitKey0;
        end else begin
          header_done = 1'b1;
        end
      end
      WaitKey0: begin
        key_bytes[0] = b;
        dphase       = WaitKey1;
      end
      WaitKey1: begin
        key_bytes[1] = b;
        dphase       = WaitKey2;
      end
      WaitKey2: begin
        key_bytes[2] = b;
        dphase       = WaitKey3;
      end
      WaitKey3: begin
        key_bytes[3] = b;
        header_done  = 1'b1;
        masked_frames++;
      end
      InPayload: begin
        beat.data     = mask_on ? (b ^ key_bytes[byte_count[KeyIdxW-1:0]]) : b;
        beat.has_data = 1'b1;
        beat.last     = (int'(byte_count) + 1 >= int'(payload_len));
        byte_count    = byte_count + 1'b1;
        produced      = 1'b1;
        if (beat.last) begin
          dphase = WaitHdr0;
        end
      end
      default: ;
    endcase
    // A finished header either opens the payload or closes an empty frame.
    if (header_done) begin
      byte_count = '0;
      frames_seen++;
      if (payload_len == 0) begin
        dphase    = WaitHdr0;
        produced  = 1'b1;
        beat.last = 1'b1;
        empty_frames++;
      end else begin
        dphase = InPayload;
      end
    end
    beat.fin    = fin_held;
    beat.opcode = opcode_held;
  endtask

  // Offer one byte in bursts with random gaps, and log what it should produce.
  task automatic offer_byte(input logic [ByteW-1:0] b, input bit pinned,
                            input frame_beat_t pinned_beat);
    logic [ByteW-1:0] rx;
    int unsigned      gap;
    bit               produced;
    frame_beat_t      beat;
    rx = b;
    // Outside the final phase, keep length codes in the short range.
    if (!allow_halt && dphase == WaitHdr1 && rx[LenW-1:0] > MaxLen) begin
      rx[LenW-1:0] = MaxLen;
    end
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    rx_byte_i  <= rx;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    advance_deframer(rx, produced, beat);
    if (pinned) begin
      expected_beats.push_back(pinned_beat);
    end else if (produced) begin
      expected_beats.push_back(beat);
    end
    beats_sent++;
  endtask

  task automatic check_field(input string name, input logic [ByteW-1:0] want,
                             input logic [ByteW-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  // Compare every result beat with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    frame_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_beats.size() == 0) begin
        $error("result beat with no expectation pending");
        error_count++;
      end else begin
        want = expected_beats.pop_front();
        check_field("data_byte", want.data, data_byte_o);
        check_field("has_data", want.has_data, has_data_o);
        check_field("fin_flag", want.fin, fin_flag_o);
        check_field("frame_opcode", want.opcode, frame_opcode_o);
        check_field("last_of_frame", want.last, last_of_frame_o);
        check_field("length_error", want.len_err, length_error_o);
        results_checked++;
      end
    end
  end

  // The sink changes its ready pattern now and then, and holds off on request.
  initial begin : result_sink
    sink_mode_e  mode;
    int unsigned mode_left;
    int unsigned tick;
    mode      = SinkFree;
    mode_left = 0;
    tick      = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = sink_mode_e'($urandom_range(3));
          mode_left = $urandom_range(32, 256);
        end
        mode_left--;
        tick++;
        case (mode)
          SinkFree:        out_ready_i <= 1'b1;
          SinkCoin:        out_ready_i <= 1'($urandom_range(1));
          SinkEveryFourth: out_ready_i <= (tick % 4 == 0);
          default:         out_ready_i <= ($urandom_range(9) != 0);
        endcase
      end
    end
  end

  // End the run if no beat moves on either side for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $error("no beat moved for %0d cycles", StallLimit);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    logic [LenW-1:0] len;
    logic            masked;
    int unsigned     noise_len;
    bit              held;
    bit              paused;
    held   = 1'b0;
    paused = 1'b0;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames, short of the final error frame.
    for (int i = 0; i < DirectedRows - TailRows; i++) begin
      offer_byte(StimTable[i].rx, StimTable[i].pinned, StimTable[i].want);
    end

    // Let everything drain before the random part.
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_beats.size() != 0);

    // Mostly well-formed frames with random content, some runs of raw noise.
    while (beats_sent < RandomBeats) begin
      if (!held && beats_sent >= RandomBeats / 3) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      if (!paused && beats_sent >= 2 * RandomBeats / 3) begin
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (expected_beats.size() != 0);
        paused = 1'b1;
      end
      if ($urandom_range(99) < 90) begin
        case ($urandom_range(9))
          0:       len = '0;
          1:       len = MaxLen;
          2:       len = LenW'($urandom_range(125));
          default: len = LenW'($urandom_range(1, 8));
        endcase
        masked = 1'($urandom_range(1));
        offer_byte(ByteW'($urandom_range(255)), 1'b0, NoBeat);
        offer_byte({masked, len}, 1'b0, NoBeat);
        if (masked) begin
          repeat (KeyDepth) offer_byte(ByteW'($urandom_range(255)), 1'b0, NoBeat);
        end
        repeat (len) offer_byte(ByteW'($urandom_range(255)), 1'b0, NoBeat);
      end else begin
        noise_len = $urandom_range(1, 6);
        repeat (noise_len) offer_byte(ByteW'($urandom_range(255)), 1'b0, NoBeat);
        while (dphase != WaitHdr0) offer_byte(ByteW'($urandom_range(255)), 1'b0, NoBeat);
      end
    end

    // Oversized length code, then bytes that must be swallowed silently.
    allow_halt = 1'b1;
    for (int i = DirectedRows - TailRows; i < DirectedRows; i++) begin
      offer_byte(StimTable[i].rx, StimTable[i].pinned, StimTable[i].want);
    end
    repeat (8) offer_byte(ByteW'($urandom_range(255)), 1'b0, NoBeat);

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_beats.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_beats.size() != 0) begin
      $error("%0d expected result beats never arrived", expected_beats.size());
      error_count++;
    end

    $display("Sent %0d input beats: %0d frame headers (%0d masked, %0d empty).",
             beats_sent, frames_seen, masked_frames, empty_frames);
    $display("Checked %0d result beats, ending on a length error and a halted stream.",
             results_checked);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
